[hw/rtl/pid_position_motor_drive_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef PID_POSITION_MOTOR_DRIVE_CORE_MACROS_SVH
`define PID_POSITION_MOTOR_DRIVE_CORE_MACROS_SVH

// Property sampled on clock, ignored while reset is high.
`define PPMD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property sampled on clock at every edge, reset included.
`define PPMD_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/ppmd_pkg.sv]
`default_nettype none

package ppmd_pkg;

   // Field widths
   localparam int DEG_W      = 22;
   localparam int PULSE_W    = 32;
   localparam int DUTY_W     = 7;
   localparam int DIR_W      = 2;
   localparam int GAIN_W     = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Datapath widths
   localparam int ABS_DEG_W  = DEG_W;        // |degree| fits unsigned
   localparam int SCALED_W   = 25;           // |degree| * 11
   localparam int QPROD_W    = 57;           // scaled * reciprocal of ten
   localparam int TGT_W      = 23;           // signed target pulses
   localparam int ERR_W      = 34;
   localparam int DIFF_W     = 35;
   localparam int SUM_W      = 48;
   localparam int CHUNK_W    = 24;           // operand slice per multiply
   localparam int OPND_W     = CHUNK_W + 1;
   localparam int MGAIN_W    = GAIN_W + 1;
   localparam int PROD_W     = OPND_W + MGAIN_W;
   localparam int ACC_W      = 82;
   localparam int FRAC_W     = 16;
   localparam int MAG_W      = ACC_W - FRAC_W;

   // 396/360 reduces to 11/10; x/10 is (x * ceil(2^35/10)) >> 35 for 32-bit x
   localparam logic [SCALED_W-1:0] DEG_MUL     = 25'd11;
   localparam logic [31:0]         RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                  RECIP_SHIFT = 35;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

   localparam int MOTOR_COUNT_DEF = 2;

   // Register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 31'd676704;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 31'd138;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 31'd34879950;
   localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = 7'd15;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RST   = 7'd99;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN  = 3'd0,
      REG_INTEG_GAIN = 3'd1,
      REG_DERIV_GAIN = 3'd2,
      REG_MIN_DUTY   = 3'd3,
      REG_MAX_DUTY   = 3'd4
   } ppmd_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ERROR,
      ST_MUL,
      ST_MAG,
      ST_DUTY
   } ppmd_state_type;

   // Multiplier operand slices, in issue order
   typedef enum logic [2:0] {
      OP_ERR_LO  = 3'd0,
      OP_ERR_HI  = 3'd1,
      OP_SUM_LO  = 3'd2,
      OP_SUM_HI  = 3'd3,
      OP_DIFF_LO = 3'd4,
      OP_DIFF_HI = 3'd5
   } ppmd_opsel_type;

   localparam logic [2:0] MUL_LAST = 3'd6;   // drain beat: accumulate only

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [DUTY_W-1:0] min_duty;
      logic [DUTY_W-1:0] max_duty;
   } ppmd_cfg_type;

   typedef struct packed {
      logic           load;
      logic           scale;
      logic           error;
      logic           mul_en;
      logic           acc_en;
      ppmd_opsel_type sel;
      logic           mag;
      logic           finish;
   } ppmd_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ppmd_stat_type;

endpackage

`default_nettype wire

[hw/rtl/ppmd_chan_if.sv]
`default_nettype none

interface ppmd_req_if
   import ppmd_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      motor_index;
   logic signed [DEG_W-1:0]   target_degree;
   logic signed [PULSE_W-1:0] measured_pulses;

   modport source (output valid, motor_index, target_degree, measured_pulses, input ready);
   modport sink   (input valid, motor_index, target_degree, measured_pulses, output ready);
endinterface

interface ppmd_rsp_if
   import ppmd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_percent;
   logic [DIR_W-1:0]  direction_code;
   logic              bridge_pin_a;
   logic              bridge_pin_b;

   modport source (output valid, duty_percent, direction_code, bridge_pin_a, bridge_pin_b,
                   input ready);
   modport sink   (input valid, duty_percent, direction_code, bridge_pin_a, bridge_pin_b,
                   output ready);
endinterface

interface ppmd_csr_if
   import ppmd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pid_position_motor_drive_core.sv]
// Position PID for up to MOTOR_COUNT DC motors, one command per beat.
// req_bus carries motor index, target angle (degrees) and encoder count;
// rsp_bus returns duty percent, stored direction and H-bridge pin levels
// (A and B swapped for motor 1). csr_bus writes gains and duty limits by
// register index at any cycle; it never stalls and ignores unknown indexes.
// One item is in flight at a time: a new request is taken only after
// the previous result is written to the output register. The steps run
// in order: the idle state takes the request, the angle is scaled, the
// error is formed, the three gain terms pass the single shared 25x32
// multiplier, each in two slices, a drain beat accumulates the last
// product, then the magnitude is taken and the duty clamped.
// While rsp_bus is stalled the last result sits in the output register
// and the next request is still accepted and computed; only the final
// write-back waits for the output register to free.
// Synchronous reset restores the register defaults, clears the per-motor
// error, error sum and direction, and drops any pending result.
`default_nettype none

module pid_position_motor_drive_core
   import ppmd_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ppmd_req_if.sink   req_bus,
   ppmd_rsp_if.source rsp_bus,
   ppmd_csr_if.sink   csr_bus
);

   ppmd_cmd_type  cmd;
   ppmd_stat_type stat;
   ppmd_cfg_type  cfg;
   logic          csr_ready;
   logic          req_ready;

   ppmd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   ppmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppmd_dpath #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .cfg                 (cfg),
      .req_motor_index     (req_bus.motor_index),
      .req_target_degree   (req_bus.target_degree),
      .req_measured_pulses (req_bus.measured_pulses),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_duty_percent    (rsp_bus.duty_percent),
      .rsp_direction_code  (rsp_bus.direction_code),
      .rsp_bridge_pin_a    (rsp_bus.bridge_pin_a),
      .rsp_bridge_pin_b    (rsp_bus.bridge_pin_b)
   );

   assign csr_bus.ready = csr_ready;
   assign req_bus.ready = req_ready;

endmodule

`default_nettype wire

[hw/rtl/ppmd_csr.sv]
`default_nettype none

module ppmd_csr
   import ppmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       csr_ready,
   output ppmd_cfg_type               cfg
);

   ppmd_cfg_type cfg_ff;
   ppmd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PROP_GAIN:  cfg_in.prop_gain  = csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_in.integ_gain = csr_data[GAIN_W-1:0];
            REG_DERIV_GAIN: cfg_in.deriv_gain = csr_data[GAIN_W-1:0];
            REG_MIN_DUTY:   cfg_in.min_duty   = csr_data[DUTY_W-1:0];
            REG_MAX_DUTY:   cfg_in.max_duty   = csr_data[DUTY_W-1:0];
            default:        cfg_in = cfg_ff;   // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= PROP_GAIN_RST;
         cfg_ff.integ_gain <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain <= DERIV_GAIN_RST;
         cfg_ff.min_duty   <= MIN_DUTY_RST;
         cfg_ff.max_duty   <= MAX_DUTY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ppmd_ctrl.sv]
`default_nettype none

module ppmd_ctrl
   import ppmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  ppmd_stat_type stat,
   output ppmd_cmd_type cmd
);

   ppmd_state_type state_ff;
   ppmd_state_type state_in;
   logic [2:0]     cnt_ff;
   logic [2:0]     cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ERROR;
         ST_ERROR: state_in = ST_MUL;
         ST_MUL:   if (cnt_ff == MUL_LAST) state_in = ST_MAG;
         ST_MAG:   state_in = ST_DUTY;
         ST_DUTY:  if (!stat.out_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = ppmd_opsel_type'(cnt_ff);
      req_ready = 1'b0;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCALE: cmd.scale = 1'b1;
         ST_ERROR: begin
            cmd.error = 1'b1;
            cnt_in    = '0;
         end
         ST_MUL: begin
            // one slice per beat, accumulate the previous product
            cmd.mul_en = (cnt_ff != MUL_LAST);
            cmd.acc_en = (cnt_ff != '0);
            cnt_in     = cnt_ff + 3'd1;
         end
         ST_MAG:  cmd.mag = 1'b1;
         ST_DUTY: cmd.finish = !stat.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ppmd_dpath.sv]
`default_nettype none

module ppmd_dpath
   import ppmd_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  ppmd_cmd_type                   cmd,
   output ppmd_stat_type                  stat,
   input  ppmd_cfg_type                   cfg,
   input  wire logic                      req_motor_index,
   input  wire logic signed [DEG_W-1:0]   req_target_degree,
   input  wire logic signed [PULSE_W-1:0] req_measured_pulses,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic [DUTY_W-1:0]              rsp_duty_percent,
   output logic [DIR_W-1:0]               rsp_direction_code,
   output logic                           rsp_bridge_pin_a,
   output logic                           rsp_bridge_pin_b
);

   localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   // Captured beat
   logic                      motor_ff;
   logic signed [DEG_W-1:0]   deg_ff;
   logic signed [PULSE_W-1:0] meas_ff;

   // Pipeline registers
   logic signed [TGT_W-1:0]  target_ff,  target_in;
   logic signed [ERR_W-1:0]  err_ff,     err_in;
   logic signed [SUM_W-1:0]  sum_ff,     sum_in;
   logic signed [DIFF_W-1:0] diff_ff,    diff_in;
   logic signed [PROD_W-1:0] prod_ff,    prod_in;
   logic                     prod_hi_ff, prod_hi_in;
   logic signed [ACC_W-1:0]  acc_ff,     acc_in;
   logic                     neg_ff,     neg_in;
   logic [MAG_W-1:0]         mag_ff,     mag_in;

   // Per-motor state
   logic signed [ERR_W-1:0] last_err_ff [MOTOR_COUNT];
   logic signed [SUM_W-1:0] err_sum_ff  [MOTOR_COUNT];
   logic [DIR_W-1:0]        dir_ff      [MOTOR_COUNT];

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_duty_ff,  rsp_duty_in;
   logic [DIR_W-1:0]  rsp_dir_ff,   rsp_dir_in;
   logic              rsp_pa_ff,    rsp_pa_in;
   logic              rsp_pb_ff,    rsp_pb_in;

   logic                       motor_ok;
   logic [MIDX_W-1:0]          midx;
   logic [ABS_DEG_W-1:0]       deg_abs;
   logic [SCALED_W-1:0]        scaled;
   logic [QPROD_W-1:0]         qprod;
   logic [ABS_DEG_W-1:0]       quot;
   logic signed [SUM_W:0]      sum_raw;
   logic signed [SUM_W-1:0]    err_wide;
   logic signed [SUM_W-1:0]    diff_wide;
   logic signed [OPND_W-1:0]   opnd;
   logic signed [MGAIN_W-1:0]  gain;
   logic signed [ACC_W-1:0]    addend;
   logic signed [ACC_W-1:0]    acc_abs;
   logic                       big;
   logic                       mag_nz;
   logic [DIR_W-1:0]           dir_old;
   logic [DIR_W-1:0]           dir_cand;
   logic [DIR_W-1:0]           dir_new;
   logic [DUTY_W-1:0]          duty;
   logic                       pin_fwd;
   logic                       pin_rev;

   assign motor_ok = (32'(motor_ff) < MOTOR_COUNT);
   assign midx     = motor_ok ? MIDX_W'(motor_ff) : '0;

   // Scale degrees to pulses: trunc(|deg| * 11 / 10), sign restored
   always_comb begin
      deg_abs   = deg_ff[DEG_W-1] ? ABS_DEG_W'(-deg_ff) : ABS_DEG_W'(deg_ff);
      scaled    = SCALED_W'(deg_abs) * DEG_MUL;
      qprod     = QPROD_W'(scaled) * QPROD_W'(RECIP_TEN);
      quot      = qprod[RECIP_SHIFT +: ABS_DEG_W];
      target_in = deg_ff[DEG_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

   // Error, saturated running sum and difference
   always_comb begin
      err_in  = ERR_W'(target_ff) - ERR_W'(meas_ff);
      sum_raw = (SUM_W+1)'(err_sum_ff[midx]) + (SUM_W+1)'(err_in);
      if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
         sum_in = sum_raw[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = sum_raw[SUM_W-1:0];
      end
      diff_in = DIFF_W'(err_in) - DIFF_W'(last_err_ff[midx]);
   end

   // Shared multiplier: 24-bit slice (low unsigned, high signed) times unsigned gain
   always_comb begin
      err_wide   = SUM_W'(err_ff);
      diff_wide  = SUM_W'(diff_ff);
      opnd       = '0;
      gain       = '0;
      prod_hi_in = 1'b0;
      case (cmd.sel)
         OP_ERR_LO: begin
            opnd = $signed({1'b0, err_wide[CHUNK_W-1:0]});
            gain = $signed({1'b0, cfg.prop_gain});
         end
         OP_ERR_HI: begin
            opnd       = $signed({err_wide[SUM_W-1], err_wide[SUM_W-1:CHUNK_W]});
            gain       = $signed({1'b0, cfg.prop_gain});
            prod_hi_in = 1'b1;
         end
         OP_SUM_LO: begin
            opnd = $signed({1'b0, sum_ff[CHUNK_W-1:0]});
            gain = $signed({1'b0, cfg.integ_gain});
         end
         OP_SUM_HI: begin
            opnd       = $signed({sum_ff[SUM_W-1], sum_ff[SUM_W-1:CHUNK_W]});
            gain       = $signed({1'b0, cfg.integ_gain});
            prod_hi_in = 1'b1;
         end
         OP_DIFF_LO: begin
            opnd = $signed({1'b0, diff_wide[CHUNK_W-1:0]});
            gain = $signed({1'b0, cfg.deriv_gain});
         end
         OP_DIFF_HI: begin
            opnd       = $signed({diff_wide[SUM_W-1], diff_wide[SUM_W-1:CHUNK_W]});
            gain       = $signed({1'b0, cfg.deriv_gain});
            prod_hi_in = 1'b1;
         end
         default: begin
            opnd = '0;
            gain = '0;
         end
      endcase
      prod_in = PROD_W'(opnd) * PROD_W'(gain);
   end

   always_comb begin
      addend = prod_hi_ff ? (ACC_W'(prod_ff) <<< CHUNK_W) : ACC_W'(prod_ff);
      acc_in = acc_ff + addend;
   end

   // Truncate toward zero: take magnitude, then drop the fraction
   always_comb begin
      neg_in  = acc_ff[ACC_W-1];
      acc_abs = neg_in ? -acc_ff : acc_ff;
      mag_in  = acc_abs[ACC_W-1:FRAC_W];
   end

   // Duty clamp, direction and pins
   always_comb begin
      big      = (mag_ff[MAG_W-1:DUTY_W] != '0) || (mag_ff[DUTY_W-1:0] >= DUTY_FULL);
      mag_nz   = (mag_ff != '0);
      dir_old  = dir_ff[midx];
      dir_cand = mag_nz ? (neg_ff ? DIR_REV : DIR_FWD) : dir_old;
      if (big) begin
         duty = cfg.max_duty;
      end else if (mag_nz && (mag_ff[DUTY_W-1:0] < cfg.min_duty)) begin
         duty = cfg.min_duty;
      end else begin
         duty = mag_ff[DUTY_W-1:0];
      end
      dir_new = (duty != '0) ? dir_cand : dir_old;
      pin_fwd = (dir_new == DIR_FWD);
      pin_rev = (dir_new == DIR_REV);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_pa_in    = rsp_pa_ff;
      rsp_pb_in    = rsp_pb_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (motor_ok) begin
            rsp_duty_in = duty;
            rsp_dir_in  = dir_new;
            // motor 1 is mounted mirrored: swap the bridge inputs
            rsp_pa_in   = motor_ff ? pin_rev : pin_fwd;
            rsp_pb_in   = motor_ff ? pin_fwd : pin_rev;
         end else begin
            rsp_duty_in = '0;
            rsp_dir_in  = DIR_NONE;
            rsp_pa_in   = 1'b0;
            rsp_pb_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         motor_ff <= req_motor_index;
         deg_ff   <= req_target_degree;
         meas_ff  <= req_measured_pulses;
      end
      if (cmd.scale) begin
         target_ff <= target_in;
      end
      if (cmd.error) begin
         err_ff  <= err_in;
         sum_ff  <= sum_in;
         diff_ff <= diff_in;
         acc_ff  <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.mul_en) begin
         prod_ff    <= prod_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (cmd.mag) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      rsp_duty_ff <= rsp_duty_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_pa_ff   <= rsp_pa_in;
      rsp_pb_ff   <= rsp_pb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_motor
      always_ff @(posedge clock) begin
         if (reset) begin
            last_err_ff[i] <= '0;
            err_sum_ff[i]  <= '0;
            dir_ff[i]      <= DIR_NONE;
         end else if (cmd.finish && motor_ok && (midx == MIDX_W'(i))) begin
            last_err_ff[i] <= err_ff;
            err_sum_ff[i]  <= sum_ff;
            dir_ff[i]      <= dir_new;
         end
      end
   end

   assign stat.out_busy      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty_percent   = rsp_duty_ff;
   assign rsp_direction_code = rsp_dir_ff;
   assign rsp_bridge_pin_a   = rsp_pa_ff;
   assign rsp_bridge_pin_b   = rsp_pb_ff;

endmodule

`default_nettype wire

[hw/rtl/ppmd_checker.sv]
`default_nettype none
`include "pid_position_motor_drive_core_macros.svh"

module ppmd_checker
   import ppmd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DUTY_W-1:0] rsp_duty,
   input wire logic [DIR_W-1:0]  rsp_dir,
   input wire logic              rsp_pin_a,
   input wire logic              rsp_pin_b
);

   `PPMD_ASSERT_RST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty), "stalled result beat changed")
   `PPMD_ASSERT_RST(a_busy_after_req, req_valid && req_ready |=> !req_ready, "request taken while an item is in flight")
   `PPMD_ASSERT_ANY(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "result pending right after reset")
   `PPMD_ASSERT_RST(a_duty_has_dir, rsp_valid && (rsp_duty != '0) |-> (rsp_dir != DIR_NONE), "nonzero duty without a direction")
   `PPMD_ASSERT_RST(a_pins_exclusive, rsp_valid |-> !(rsp_pin_a && rsp_pin_b) && ((rsp_dir != DIR_NONE) || !(rsp_pin_a || rsp_pin_b)), "bridge pins disagree with direction")

endmodule

bind pid_position_motor_drive_core ppmd_checker u_ppmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_duty  (rsp_bus.duty_percent),
   .rsp_dir   (rsp_bus.direction_code),
   .rsp_pin_a (rsp_bus.bridge_pin_a),
   .rsp_pin_b (rsp_bus.bridge_pin_b)
);

`default_nettype wire

[tb/testbench.sv]
module testbench
   import ppmd_pkg::*;
();

   localparam longint SUM_TOP = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam int     Q_ONE   = 1 << FRAC_W;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic [DIR_W-1:0]  dir;
      logic              pin_a;
      logic              pin_b;
   } drive_out_type;

   logic clock;
   logic reset;

   ppmd_req_if req_bus ();
   ppmd_rsp_if rsp_bus ();
   ppmd_csr_if csr_bus ();

   pid_position_motor_drive_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Controller copy: gains, per-motor loop state, expected drive outputs
   ppmd_cfg_type     gains;
   longint           prev_err   [MOTOR_COUNT_DEF];
   longint           err_total  [MOTOR_COUNT_DEF];
   logic [DIR_W-1:0] held_dir   [MOTOR_COUNT_DEF];
   longint           track_off  [MOTOR_COUNT_DEF];
   drive_out_type    pending_drive[$];

   int unsigned fault_count = 0;
   int unsigned idle_odds   = 3;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      #8_000_000;
      $display("FAIL pid_position_motor_drive_core");
      $finish;
   end

   function automatic drive_out_type drive_predict(logic motor, logic signed [DEG_W-1:0] deg,
                                                   logic signed [PULSE_W-1:0] pulses);
      drive_out_type      r;
      longint             tgt, err, diff, total;
      logic signed [95:0] e_w, s_w, d_w, kp_w, ki_w, kd_w, acc;
      logic [95:0]        cmd;
      logic               neg;
      logic [DIR_W-1:0]   dir;
      logic [DUTY_W-1:0]  duty;
      tgt = (longint'(deg) * 396) / 360;
      err = tgt - longint'(pulses);
      total = err_total[motor] + err;
      if (total > SUM_TOP) total = SUM_TOP;
      else if (total < -SUM_TOP - 1) total = -SUM_TOP - 1;
      err_total[motor] = total;
      diff = err - prev_err[motor];
      prev_err[motor] = err;
      e_w = 96'(err);
      s_w = 96'(total);
      d_w = 96'(diff);
      kp_w = 96'(gains.prop_gain);
      ki_w = 96'(gains.integ_gain);
      kd_w = 96'(gains.deriv_gain);
      acc = e_w * kp_w + s_w * ki_w + d_w * kd_w;
      // truncate toward zero: shift the magnitude, not the signed sum
      neg = acc[95];
      cmd = (neg ? -acc : acc) >> FRAC_W;
      dir = held_dir[motor];
      if (cmd != 0) dir = neg ? DIR_REV : DIR_FWD;
      if (cmd >= 100) duty = gains.max_duty;
      else if (cmd != 0 && cmd < gains.min_duty) duty = gains.min_duty;
      else duty = cmd[DUTY_W-1:0];
      if (duty != 0) held_dir[motor] = dir;
      r.duty = duty;
      r.dir = held_dir[motor];
      r.pin_a = (held_dir[motor] == DIR_FWD);
      r.pin_b = (held_dir[motor] == DIR_REV);
      if (motor) begin
         r.pin_a = (held_dir[motor] == DIR_REV);
         r.pin_b = (held_dir[motor] == DIR_FWD);
      end
      return r;
   endfunction

   // Response stalls in bursts
   initial begin : rsp_stall
      int unsigned hold;
      hold = 0;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold != 0) hold--;
         else if (idle_odds != 0 && $urandom_range(1, 16) <= idle_odds)
            hold = $urandom_range(1, 17);
         rsp_bus.ready = (hold == 0);
      end
   end

   always @(posedge clock) begin : check_drive
      drive_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_drive.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected beat: duty %0d dir %0d a %0b b %0b",
                        rsp_bus.duty_percent, rsp_bus.direction_code,
                        rsp_bus.bridge_pin_a, rsp_bus.bridge_pin_b);
         end else begin
            want = pending_drive.pop_front();
            if (rsp_bus.duty_percent !== want.duty || rsp_bus.direction_code !== want.dir ||
                rsp_bus.bridge_pin_a !== want.pin_a || rsp_bus.bridge_pin_b !== want.pin_b) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: duty %0d/%0d dir %0d/%0d a %0b/%0b b %0b/%0b (exp/act)",
                           want.duty, rsp_bus.duty_percent, want.dir, rsp_bus.direction_code,
                           want.pin_a, rsp_bus.bridge_pin_a, want.pin_b, rsp_bus.bridge_pin_b);
            end
         end
      end
   end

   task automatic send_cmd(logic motor, logic signed [DEG_W-1:0] deg,
                           logic signed [PULSE_W-1:0] pulses);
      int unsigned gap;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(1, 16) <= idle_odds) begin
         gap = $urandom_range(1, 17);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.motor_index = motor;
      req_bus.target_degree = deg;
      req_bus.measured_pulses = pulses;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_drive.push_back(drive_predict(motor, deg, pulses));
   endtask

   task automatic req_park();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Drive the encoder so the loop error wanders slowly around zero
   task automatic send_tracking(int spread);
      logic   motor;
      int     deg;
      longint tgt;
      motor = 1'($urandom_range(0, 1));
      deg = $urandom_range(0, 7200) - 3600;
      if ($urandom_range(0, 9) == 0) deg = int'($urandom) >>> 10;
      if ($urandom_range(0, 19) == 0)
         track_off[motor] = longint'($urandom_range(0, 2 * spread)) - spread;
      else
         track_off[motor] += longint'($urandom_range(0, 6)) - 3;
      if (track_off[motor] > spread) track_off[motor] = spread;
      if (track_off[motor] < -spread) track_off[motor] = -spread;
      tgt = (longint'(deg) * 396) / 360;
      send_cmd(motor, DEG_W'(deg), PULSE_W'(tgt - track_off[motor]));
   endtask

   task automatic send_noise();
      send_cmd(1'($urandom_range(0, 1)), DEG_W'($urandom), PULSE_W'($urandom));
   endtask

   task automatic wait_idle();
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_PROP_GAIN:  gains.prop_gain = val;
         REG_INTEG_GAIN: gains.integ_gain = val;
         REG_DERIV_GAIN: gains.deriv_gain = val;
         REG_MIN_DUTY:   gains.min_duty = val[DUTY_W-1:0];
         REG_MAX_DUTY:   gains.max_duty = val[DUTY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic apply_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                              logic [GAIN_W-1:0] kd, logic [DUTY_W-1:0] lo,
                              logic [DUTY_W-1:0] hi);
      wait_idle();
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INTEG_GAIN, ki);
      write_reg(REG_DERIV_GAIN, kd);
      write_reg(REG_MIN_DUTY, CSR_DATA_W'(lo));
      write_reg(REG_MAX_DUTY, CSR_DATA_W'(hi));
   endtask

   task automatic test_reset_defaults();
      logic signed [DEG_W-1:0]   deg_hi, deg_lo;
      logic signed [PULSE_W-1:0] pul_hi, pul_lo;
      deg_hi = {1'b0, {(DEG_W-1){1'b1}}};
      deg_lo = {1'b1, {(DEG_W-1){1'b0}}};
      pul_hi = {1'b0, {(PULSE_W-1){1'b1}}};
      pul_lo = {1'b1, {(PULSE_W-1){1'b0}}};
      send_cmd(1'b0, '0, '0);
      send_cmd(1'b0, '0, -1);        // derivative kick, full duty forward
      send_cmd(1'b0, '0, -1);        // small command raised to minimum duty
      send_cmd(1'b0, '0, '0);        // kick back, reverse
      send_cmd(1'b0, '0, '0);        // zero command keeps reverse
      send_cmd(1'b1, DEG_W'(9), 9);  // degree conversion truncates
      send_cmd(1'b1, DEG_W'(-9), '0);
      send_cmd(1'b1, DEG_W'(-1), -1);
      send_cmd(1'b1, deg_hi, pul_lo);
      send_cmd(1'b0, deg_lo, pul_hi);
      send_cmd(1'b0, deg_hi, pul_hi);
      send_cmd(1'b1, deg_lo, pul_lo);
      req_park();
   endtask

   task automatic test_duty_limits();
      // unit proportional gain: command equals the error
      apply_gains(GAIN_W'(Q_ONE), '0, '0, 7'd0, 7'd127);
      send_cmd(1'b0, '0, '0);
      send_cmd(1'b0, '0, -1);
      send_cmd(1'b0, '0, -50);
      send_cmd(1'b0, '0, -99);
      send_cmd(1'b0, '0, -100);
      send_cmd(1'b1, '0, 150);
      req_park();
      apply_gains(GAIN_W'(Q_ONE), '0, '0, 7'd100, 7'd0);
      send_cmd(1'b0, '0, 3);
      send_cmd(1'b0, '0, -200);      // clamps to zero duty, direction held
      send_cmd(1'b1, '0, 200);
      req_park();
      apply_gains('1, '1, '1, 7'd0, 7'd100);
      send_cmd(1'b0, {1'b0, {(DEG_W-1){1'b1}}}, {1'b1, {(PULSE_W-1){1'b0}}});
      send_cmd(1'b1, {1'b1, {(DEG_W-1){1'b0}}}, {1'b0, {(PULSE_W-1){1'b1}}});
      send_cmd(1'b0, '0, '0);
      req_park();
   endtask

   task automatic test_unknown_index();
      apply_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, MIN_DUTY_RST, MAX_DUTY_RST);
      for (int k = int'(REG_MAX_DUTY) + 1; k < (1 << CSR_IDX_W); k++)
         write_reg(CSR_IDX_W'(k), CSR_DATA_W'($urandom));
      repeat (20) send_tracking(30);
      req_park();
   endtask

   task automatic test_tracking();
      for (int phase = 0; phase < 8; phase++) begin
         idle_odds = $urandom_range(0, 6);
         if (phase == 0)
            apply_gains(GAIN_W'(Q_ONE), '0, '0, 7'd0, 7'd127);
         else
            apply_gains(GAIN_W'($urandom_range(0, 1 << 18)),
                        GAIN_W'($urandom_range(0, 1 << 11)),
                        GAIN_W'($urandom_range(0, 1 << 18)), 7'($urandom_range(0, 30)),
                        7'($urandom_range(1, 100)));
         repeat (100) send_tracking($urandom_range(5, 60));
         req_park();
      end
   endtask

   task automatic test_random_gains();
      for (int phase = 0; phase < 4; phase++) begin
         idle_odds = $urandom_range(1, 8);
         apply_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
         repeat (60) begin
            if ($urandom_range(0, 1)) send_noise();
            else send_tracking(200);
         end
         req_park();
      end
   endtask

   task automatic test_noise();
      idle_odds = 4;
      apply_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, MIN_DUTY_RST, MAX_DUTY_RST);
      repeat (150) send_noise();
      req_park();
   endtask

   task automatic test_steady();
      apply_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, MIN_DUTY_RST, MAX_DUTY_RST);
      idle_odds = 0;
      repeat (300) send_tracking(3);
      req_park();
   endtask

   initial begin : run
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.motor_index = 1'b0;
      req_bus.target_degree = '0;
      req_bus.measured_pulses = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      gains.prop_gain = PROP_GAIN_RST;
      gains.integ_gain = INTEG_GAIN_RST;
      gains.deriv_gain = DERIV_GAIN_RST;
      gains.min_duty = MIN_DUTY_RST;
      gains.max_duty = MAX_DUTY_RST;
      for (int m = 0; m < MOTOR_COUNT_DEF; m++) begin
         prev_err[m] = 0;
         err_total[m] = 0;
         held_dir[m] = DIR_NONE;
         track_off[m] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_duty_limits();
      test_unknown_index();
      test_tracking();
      test_random_gains();
      test_noise();
      test_steady();
      wait_idle();

      if (fault_count == 0 && pending_drive.size() == 0)
         $display("PASS pid_position_motor_drive_core");
      else
         $display("FAIL pid_position_motor_drive_core");
      $finish;
   end

endmodule
